/* rtl/bdai_pkg.sv */
// shared constants and payload types of the block-diagonal store and inverter
package bdai_pkg;

  localparam int NODES     = 1024;
  localparam int BLOCK_DIM = 4;
  localparam int ROWS      = NODES * BLOCK_DIM;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int DW        = 32;
  localparam int ROW_W     = DW * BLOCK_DIM;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ACCUM  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         node_index;
    logic [1:0]         row_index;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
  } req_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [31:0] inv_0;
    logic signed [31:0] inv_1;
    logic signed [31:0] inv_2;
    logic signed [31:0] inv_3;
    logic               singular;
    logic               last_row;
  } rsp_t;

endpackage

/* rtl/block_diag_assemble_invert_4x4.sv */
// accumulate, clear: one item at a time, ready only when idle
// invert: 148 products on one shared bit-serial multiply-accumulate
// unit and 16 quotients on one restoring divider
// a singular block skips the divider and gives its four zero rows right away
// reset: asynchronous, then a pass over all 4096 rows zeroes the block memory, one row a cycle,
// while the input stays not ready
module block_diag_assemble_invert_4x4
  import bdai_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int ACC_W = 132;
  localparam int COF_W = 97;
  localparam int T_W   = 65;
  localparam int NUM_W = 129;
  localparam int REM_W = 131;

  localparam logic [3:0] S_WIPE   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ZERO   = 4'd2;
  localparam logic [3:0] S_ACC_WR = 4'd3;
  localparam logic [3:0] S_LD_RD  = 4'd4;
  localparam logic [3:0] S_LD_CAP = 4'd5;
  localparam logic [3:0] S_MUL_A  = 4'd6;
  localparam logic [3:0] S_MUL_B  = 4'd7;
  localparam logic [3:0] S_MUL_RUN= 4'd8;
  localparam logic [3:0] S_MUL_END= 4'd9;
  localparam logic [3:0] S_DIV_SET= 4'd10;
  localparam logic [3:0] S_DIV_RUN= 4'd11;
  localparam logic [3:0] S_DIV_END= 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [ROW_AW-1:0] wipe_q, wipe_d;
  req_t req_q, req_d;
  logic [1:0] k_q, k_d;
  logic [3:0] cof_cnt_q, cof_cnt_d;
  logic [3:0] term_q, term_d;
  logic det_ph_q, det_ph_d;
  logic [1:0] r_q, r_d, j_q, j_d;

  logic signed [DW-1:0]    m_q [16];
  logic signed [DW-1:0]    m_d [16];
  logic signed [T_W-1:0]   t_q [3];
  logic signed [T_W-1:0]   t_d [3];
  logic signed [COF_W-1:0] cof_q [16];
  logic signed [COF_W-1:0] cof_d [16];

  logic signed [ACC_W-1:0] acc_q, acc_d, a_sh_q, a_sh_d;
  logic [DW-1:0] b_q, b_d;
  logic [4:0] mcnt_q, mcnt_d;
  logic sub_q, sub_d;

  logic sing_q, sing_d, det_neg_q, det_neg_d, neg_q, neg_d, big_q, big_d;
  logic [REM_W-1:0] den_q, den_d, rem_q, rem_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [32:0] quo_q, quo_d;
  logic [7:0] dcnt_q, dcnt_d;
  logic signed [DW-1:0] inv_q [4];
  logic signed [DW-1:0] inv_d [4];

  logic ram_we;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  bdai_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // entry of the block at minor position (p, q) of the cofactor of (er, ec)
  function automatic logic [3:0] ent(input logic [1:0] er, input logic [1:0] ec,
                                     input logic [1:0] p, input logic [1:0] q);
    logic [1:0] rr, cc;
    rr = (p < er) ? p : p + 2'd1;
    cc = (q < ec) ? q : q + 2'd1;
    return {rr, cc};
  endfunction

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return s[DW-1:0];
  endfunction

  logic [1:0] ap, aq, bp, bq;
  logic [3:0] a_idx, b_idx, m_idx;
  logic signed [DW-1:0] m_rd;
  logic [3:0] cof_idx;
  logic signed [COF_W-1:0] cof_rd;
  logic signed [T_W-1:0] t_rd;
  logic parity;

  always_comb begin
    ap = 2'd1; aq = 2'd1; bp = 2'd2; bq = 2'd2;
    unique case (term_q)
      4'd0: begin ap = 2'd1; aq = 2'd1; bp = 2'd2; bq = 2'd2; end
      4'd1: begin ap = 2'd1; aq = 2'd2; bp = 2'd2; bq = 2'd1; end
      4'd2: begin ap = 2'd1; aq = 2'd0; bp = 2'd2; bq = 2'd2; end
      4'd3: begin ap = 2'd1; aq = 2'd2; bp = 2'd2; bq = 2'd0; end
      4'd4: begin ap = 2'd1; aq = 2'd0; bp = 2'd2; bq = 2'd1; end
      4'd5: begin ap = 2'd1; aq = 2'd1; bp = 2'd2; bq = 2'd0; end
      4'd6: begin bp = 2'd0; bq = 2'd0; end
      4'd7: begin bp = 2'd0; bq = 2'd1; end
      4'd8: begin bp = 2'd0; bq = 2'd2; end
      default: begin end
    endcase
    a_idx = ent(cof_cnt_q[3:2], cof_cnt_q[1:0], ap, aq);
    b_idx = det_ph_q ? term_q : ent(cof_cnt_q[3:2], cof_cnt_q[1:0], bp, bq);
    m_idx = (state_q == S_MUL_A) ? a_idx : b_idx;
    m_rd  = m_q[m_idx];
    cof_idx = (state_q == S_DIV_SET) ? {j_q, r_q} : term_q;
    cof_rd  = cof_q[cof_idx];
    unique case (term_q)
      4'd6:    t_rd = t_q[0];
      4'd7:    t_rd = t_q[1];
      default: t_rd = t_q[2];
    endcase
    parity = cof_cnt_q[2] ^ cof_cnt_q[0];
  end

  logic mul_neg;
  logic [ACC_W-1:0] addend;
  logic [REM_W-1:0] rem2;
  logic [REM_W:0] diff;
  logic div_ge;
  logic [ACC_W-1:0] acc_abs;
  logic [COF_W-1:0] cof_abs;
  logic [ROW_AW-1:0] acc_addr;
  logic in_ok;

  always_comb begin
    mul_neg = sub_q ^ (mcnt_q == 5'd31);
    addend  = mul_neg ? ~a_sh_q : a_sh_q;
    rem2    = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
    diff    = {1'b0, rem2} - {1'b0, den_q};
    div_ge  = !diff[REM_W];
    acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
    cof_abs = cof_rd[COF_W-1] ? -cof_rd : cof_rd;
    acc_addr = ROW_AW'({in_req_i.node_index, in_req_i.row_index});
    in_ok = (32'(in_req_i.node_index) < 32'(NODES));
  end

  always_comb begin
    state_d = state_q; wipe_d = wipe_q; req_d = req_q; k_d = k_q;
    cof_cnt_d = cof_cnt_q; term_d = term_q; det_ph_d = det_ph_q;
    r_d = r_q; j_d = j_q;
    m_d = m_q; t_d = t_q; cof_d = cof_q;
    acc_d = acc_q; a_sh_d = a_sh_q; b_d = b_q; mcnt_d = mcnt_q; sub_d = sub_q;
    sing_d = sing_q; det_neg_d = det_neg_q; neg_d = neg_q; big_d = big_q;
    den_d = den_q; rem_d = rem_q; num_d = num_q; quo_d = quo_q; dcnt_d = dcnt_q;
    inv_d = inv_q;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;

    unique case (state_q)
      S_WIPE: begin
        ram_we = 1'b1;
        ram_waddr = wipe_q;
        wipe_d = wipe_q + 1'b1;
        if (wipe_q == ROW_AW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = acc_addr;
        if (in_valid_i && in_ok) begin
          req_d = in_req_i;
          k_d = 2'd0;
          unique case (in_req_i.opcode)
            OP_CLEAR:  state_d = S_ZERO;
            OP_ACCUM:  state_d = S_ACC_WR;
            OP_INVERT: state_d = S_LD_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ZERO: begin
        ram_we = 1'b1;
        ram_waddr = ROW_AW'({req_q.node_index, k_q});
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = S_IDLE;
        end
      end
      S_ACC_WR: begin
        ram_we = 1'b1;
        ram_waddr = ROW_AW'({req_q.node_index, req_q.row_index});
        ram_wdata = {sat_add(ram_rdata[3*DW +: DW], req_q.value_3),
                     sat_add(ram_rdata[2*DW +: DW], req_q.value_2),
                     sat_add(ram_rdata[1*DW +: DW], req_q.value_1),
                     sat_add(ram_rdata[0 +: DW], req_q.value_0)};
        state_d = S_IDLE;
      end
      S_LD_RD: begin
        ram_raddr = ROW_AW'({req_q.node_index, k_q});
        state_d = S_LD_CAP;
      end
      S_LD_CAP: begin
        for (int c = 0; c < 4; c++) begin
          m_d[{k_q, 2'(c)}] = ram_rdata[c*DW +: DW];
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          cof_cnt_d = 4'd0;
          term_d = 4'd0;
          det_ph_d = 1'b0;
          state_d = S_MUL_A;
        end else begin
          state_d = S_LD_RD;
        end
      end
      S_MUL_A: begin
        if (det_ph_q) begin
          a_sh_d = ACC_W'(cof_rd);
          sub_d = 1'b0;
          if (term_q == 4'd0) acc_d = '0;
        end else if (term_q < 4'd6) begin
          a_sh_d = ACC_W'(m_rd);
          sub_d = term_q[0];
          if (!term_q[0]) acc_d = '0;
        end else begin
          a_sh_d = ACC_W'(t_rd);
          sub_d = (term_q == 4'd7) ^ parity;
          if (term_q == 4'd6) acc_d = '0;
        end
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        b_d = m_rd;
        mcnt_d = 5'd0;
        state_d = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        // bit 31 of the multiplier carries negative weight
        if (b_q[0]) begin
          acc_d = acc_q + addend + ACC_W'(mul_neg);
        end
        a_sh_d = a_sh_q <<< 1;
        b_d = b_q >> 1;
        mcnt_d = mcnt_q + 5'd1;
        if (mcnt_q == 5'd31) begin
          state_d = S_MUL_END;
        end
      end
      S_MUL_END: begin
        state_d = S_MUL_A;
        if (det_ph_q) begin
          if (term_q == 4'd3) begin
            sing_d = (acc_q == '0);
            det_neg_d = acc_q[ACC_W-1];
            den_d = acc_abs[REM_W-1:0];
            r_d = 2'd0;
            j_d = 2'd0;
            state_d = S_DIV_SET;
          end else begin
            term_d = term_q + 4'd1;
          end
        end else if (term_q == 4'd8) begin
          cof_d[cof_cnt_q] = COF_W'(acc_q);
          term_d = 4'd0;
          cof_cnt_d = cof_cnt_q + 4'd1;
          if (cof_cnt_q == 4'd15) begin
            det_ph_d = 1'b1;
          end
        end else begin
          if (term_q[0] && term_q < 4'd6) begin
            t_d[term_q[2:1]] = T_W'(acc_q);
          end
          term_d = term_q + 4'd1;
        end
      end
      S_DIV_SET: begin
        if (sing_q) begin
          for (int c = 0; c < 4; c++) begin
            inv_d[c] = '0;
          end
          state_d = S_EMIT;
        end else begin
          neg_d = cof_rd[COF_W-1] ^ det_neg_q;
          num_d = {cof_abs, 32'b0};
          rem_d = '0;
          quo_d = '0;
          big_d = 1'b0;
          dcnt_d = 8'd0;
          state_d = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        rem_d = div_ge ? diff[REM_W-1:0] : rem2;
        num_d = num_q << 1;
        quo_d = {quo_q[31:0], div_ge};
        big_d = big_q | quo_q[32];
        dcnt_d = dcnt_q + 8'd1;
        if (dcnt_q == 8'(NUM_W - 1)) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        if (!neg_q) begin
          inv_d[j_q] = (big_q || quo_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : quo_q[31:0];
        end else begin
          inv_d[j_q] = (big_q || quo_q > 33'h080000000) ? 32'h80000000 : -quo_q[31:0];
        end
        j_d = j_q + 2'd1;
        state_d = (j_q == 2'd3) ? S_EMIT : S_DIV_SET;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          r_d = r_q + 2'd1;
          j_d = 2'd0;
          state_d = (r_q == 2'd3) ? S_IDLE : S_DIV_SET;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
      wipe_q <= '0;
      k_q <= 2'd0;
      cof_cnt_q <= 4'd0;
      term_q <= 4'd0;
      det_ph_q <= 1'b0;
      r_q <= 2'd0;
      j_q <= 2'd0;
      mcnt_q <= 5'd0;
      dcnt_q <= 8'd0;
    end else begin
      state_q <= state_d;
      wipe_q <= wipe_d;
      k_q <= k_d;
      cof_cnt_q <= cof_cnt_d;
      term_q <= term_d;
      det_ph_q <= det_ph_d;
      r_q <= r_d;
      j_q <= j_d;
      mcnt_q <= mcnt_d;
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    m_q <= m_d;
    t_q <= t_d;
    cof_q <= cof_d;
    acc_q <= acc_d;
    a_sh_q <= a_sh_d;
    b_q <= b_d;
    sub_q <= sub_d;
    sing_q <= sing_d;
    det_neg_q <= det_neg_d;
    neg_q <= neg_d;
    big_q <= big_d;
    den_q <= den_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    inv_q <= inv_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  always_comb begin
    out_rsp_o.out_row  = r_q;
    out_rsp_o.inv_0    = inv_q[0];
    out_rsp_o.inv_1    = inv_q[1];
    out_rsp_o.inv_2    = inv_q[2];
    out_rsp_o.inv_3    = inv_q[3];
    out_rsp_o.singular = sing_q;
    out_rsp_o.last_row = (r_q == 2'd3);
  end

endmodule

/* rtl/bdai_ram.sv */
// generic single-write, single-read ram with registered read data
module bdai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
